[rtl/filament_slip_monitor_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the filament slip monitor
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FILAMENT_SLIP_MONITOR_CORE_ASSERT_SVH
`define FILAMENT_SLIP_MONITOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSMON_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fsmon: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FSMON_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fsmon: next-cycle check failed");

`endif

[rtl/fsmon_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmon_pkg
// Types and constants shared by the filament slip monitor modules.
// ----------------------------------------------------------------------------
package fsmon_pkg;

    // Command codes of an input beat.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_DRAIN = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MIN_STEPS  = 2'd0;
    localparam logic [1:0] REG_LIMIT_EN   = 2'd1;
    localparam logic [1:0] REG_CAL_VALUE  = 2'd2;
    localparam logic [1:0] REG_CAL_SHIFT  = 2'd3;
    localparam int         APB_AW         = 4;

    localparam int RING_DEPTH_DEF = 16;
    localparam int MAX_RES        = 16;
    localparam int LEFT_W         = $clog2(MAX_RES + 1);

    // Arithmetic widths of the slip path.
    localparam int PROD_W = 48;
    localparam int ACC_W  = 16;

    // Encoder wrap constants.
    localparam logic signed [11:0] POS_HALF = 12'sd512;
    localparam logic signed [11:0] POS_SPAN = 12'sd1024;

    // Accumulator saturation bound.
    localparam logic signed [16:0] ACC_MAX = 17'sd32767;

    // Limiter constants (slip is scaled by 128).
    localparam logic signed [15:0] SLIP_UNIT  = 16'sd128;
    localparam logic signed [15:0] SLIP_CEIL  = 16'sd512;
    localparam logic signed [15:0] LIM_OFFSET = 16'sd13;
    localparam logic [12:0]        SLOW_NONE  = 13'd1024;
    localparam logic [12:0]        SLOW_MAX   = 13'd4096;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        encoder_word;
        logic signed [31:0] stepper_position;
        logic [31:0]        time_ms;
    } t_in_item;

    typedef struct packed {
        logic [9:0]         encoder_pos;
        logic               parity_error;
        logic signed [15:0] slip;
        logic [12:0]        slowdown;
        logic               limiting;
        logic               record_valid;
        logic [15:0]        record_dt;
        logic signed [15:0] record_stepper;
        logic signed [15:0] record_sensor;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] dt;
        logic [15:0] stepper;
        logic [15:0] sensor;
    } t_record;

    typedef struct packed {
        logic push;
        logic pop;
        logic rd;
    } t_ring_ctl;

endpackage

[rtl/fsmon_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmon_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module fsmon_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [fsmon_pkg::PROD_W-1:0]   i_dividend,
    input  logic signed [fsmon_pkg::ACC_W-1:0]    i_divisor,
    output logic                                  o_done,
    output logic signed [fsmon_pkg::PROD_W-1:0]   o_quot
);
    import fsmon_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic                     r_busy;
    logic                     r_fix;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic [PROD_W-1:0]        r_num;
    logic [ACC_W-1:0]         r_rem;
    logic [ACC_W-1:0]         r_den;
    logic                     r_neg;
    logic signed [PROD_W-1:0] r_quot;

    logic [ACC_W:0]  w_shift;
    logic            w_ge;
    logic [ACC_W:0]  w_diff;

    assign w_shift = {r_rem, r_num[PROD_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROD_W - 1);
                r_num  <= i_dividend[PROD_W-1] ? PROD_W'(-i_dividend) : i_dividend;
                r_den  <= i_divisor[ACC_W-1] ? ACC_W'(-i_divisor) : i_divisor;
                r_neg  <= i_dividend[PROD_W-1] ^ i_divisor[ACC_W-1];
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[PROD_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[ACC_W-1:0] : w_shift[ACC_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                // Apply the quotient sign once the magnitude is complete.
                r_quot <= r_neg ? -$signed(r_num) : $signed(r_num);
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[rtl/fsmon_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmon_ring
// Window record ring that overwrites its oldest entry when full.
// ----------------------------------------------------------------------------
module fsmon_ring #(
    parameter int RING_DEPTH = fsmon_pkg::RING_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  fsmon_pkg::t_ring_ctl                  i_ctl,
    input  fsmon_pkg::t_record                    i_wrec,
    output fsmon_pkg::t_record                    o_rrec,
    output logic [$clog2(RING_DEPTH+1)-1:0]       o_count
);
    import fsmon_pkg::*;

    localparam int HW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    t_record        r_mem [RING_DEPTH];
    t_record        r_rdata;
    logic [HW-1:0]  r_head;
    logic [CW-1:0]  r_count;

    logic           w_full;
    logic [HW-1:0]  w_head_inc;
    logic [CW:0]    w_sum;
    logic [CW:0]    w_slot;
    logic [HW-1:0]  w_waddr;

    assign w_full     = r_count == CW'(RING_DEPTH);
    assign w_head_inc = (r_head == HW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_sum      = (CW + 1)'(r_head) + (CW + 1)'(r_count);
    assign w_slot     = (w_sum >= (CW + 1)'(RING_DEPTH)) ? w_sum - (CW + 1)'(RING_DEPTH) : w_sum;
    // When full, the new record lands on the oldest slot.
    assign w_waddr    = w_full ? r_head : w_slot[HW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_ctl.push) begin
            if (w_full) begin
                r_head <= w_head_inc;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end else if (i_ctl.pop) begin
            r_head  <= w_head_inc;
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[w_waddr] <= i_wrec;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[r_head];
        end
    end

    assign o_rrec  = r_rdata;
    assign o_count = r_count;

endmodule

[rtl/filament_slip_monitor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filament_slip_monitor_core
// Filament slip monitor: encoder tracking, slip ratio, limiter, record ring.
// ----------------------------------------------------------------------------
// Input beats carry a command, the encoder word, the stepper position and a
// millisecond time. The block takes one beat, works on it alone, and then
// returns to idle; o_in_ready is high only while idle. Results leave through a
// single output register, so a new input beat may be taken while the last
// result still waits for i_out_ready.
// A tick without a slip evaluation and a start go from the sense state to the
// emit state, which loads the output register and returns to idle. A tick that
// evaluates runs the window through the delta state, the multiplier state and
// the serial divider (one quotient bit per cycle over 48 bits, then a sign
// step) before the limiter state. An evaluation on an empty accumulator skips
// the divider and goes from the multiplier state straight to the limiter.
// A drain gives up to 16 results. Each record is read through the registered
// read port of the memory before it is emitted, and the next read starts only
// after the last record has left.
// A stalled receiver holds the sequencer in its emit state; nothing is lost.
// Synchronous reset clears the tracking state, the limiter and the ring
// pointers. The record memory itself is not cleared; entries are only read
// after they have been written. Configuration writes over the APB port take
// effect at once and should be made while the block is idle.
// ----------------------------------------------------------------------------
module filament_slip_monitor_core #(
    parameter int RING_DEPTH = fsmon_pkg::RING_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  fsmon_pkg::t_in_item             i_in_data,
    // Output channel.
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output fsmon_pkg::t_out_item            o_out_data,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fsmon_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import fsmon_pkg::*;

    localparam int CW = $clog2(RING_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SENSE,
        S_DELTA,
        S_PROD,
        S_DIVGO,
        S_DIV,
        S_LIMIT,
        S_EMIT,
        S_RD,
        S_DOUT
    } t_state;

    // Configuration registers.
    logic [14:0] r_min_steps;
    logic        r_limit_en;
    logic [15:0] r_cal_value;
    logic [4:0]  r_cal_shift;

    // Sequencer and tracking state.
    t_state                   r_state,    n_state;
    logic [1:0]               r_cmd,      n_cmd;
    logic [15:0]              r_word,     n_word;
    logic signed [31:0]       r_stepper,  n_stepper;
    logic [31:0]              r_time,     n_time;
    logic [9:0]               r_held,     n_held;
    logic                     r_perr,     n_perr;
    logic signed [15:0]       r_accum,    n_accum;
    logic signed [31:0]       r_base,     n_base;
    logic [15:0]              r_win,      n_win;
    logic signed [15:0]       r_slip,     n_slip;
    logic [12:0]              r_slowdown, n_slowdown;
    logic                     r_limiting, n_limiting;
    logic signed [31:0]       r_delta,    n_delta;
    logic signed [PROD_W-1:0] r_prod,     n_prod;
    logic [LEFT_W-1:0]        r_left,     n_left;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out_data,  n_out_data;

    // Encoder and accumulator path.
    logic                     w_perr;
    logic [9:0]               w_pos;
    logic signed [11:0]       w_dy_raw;
    logic signed [11:0]       w_dy;
    logic signed [16:0]       w_acc_sum;
    logic signed [15:0]       w_acc_sat;
    logic signed [15:0]       w_acc_abs;
    logic                     w_eval;

    // Limiter path.
    logic signed [15:0]       w_lim_raw;
    logic [9:0]               w_lim_s;
    logic                     w_lim_on;

    // Shared units.
    logic                     w_div_start;
    logic                     w_div_done;
    logic signed [PROD_W-1:0] w_quot;
    logic signed [PROD_W-1:0] w_shifted;
    t_ring_ctl                w_ring_ctl;
    t_record                  w_wrec;
    t_record                  w_rrec;
    logic [CW-1:0]            w_count;
    logic                     w_out_free;
    logic                     w_cfg_wr;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; reads are
    // answered combinationally with the register zero-extended.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_steps <= 15'd128;
            r_limit_en  <= 1'b1;
            r_cal_value <= 16'd1;
            r_cal_shift <= 5'd0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_MIN_STEPS: r_min_steps <= pwdata[14:0];
                REG_LIMIT_EN:  r_limit_en  <= pwdata[0];
                REG_CAL_VALUE: r_cal_value <= pwdata[15:0];
                REG_CAL_SHIFT: r_cal_shift <= pwdata[4:0];
                default:       r_min_steps <= r_min_steps;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MIN_STEPS: prdata = {17'd0, r_min_steps};
            REG_LIMIT_EN:  prdata = {31'd0, r_limit_en};
            REG_CAL_VALUE: prdata = {16'd0, r_cal_value};
            REG_CAL_SHIFT: prdata = {27'd0, r_cal_shift};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Encoder read. The whole word must have even parity; on an error the
    // held position stands and the delta is zero. A change of more than
    // half a turn is taken as a wrap through zero; exactly half a turn is
    // kept as it is.
    // ------------------------------------------------------------------
    assign w_perr   = ^r_word;
    assign w_pos    = w_perr ? r_held : r_word[15:6];
    assign w_dy_raw = $signed({2'b00, w_pos}) - $signed({2'b00, r_held});

    always_comb begin
        if (w_dy_raw < -POS_HALF) begin
            w_dy = w_dy_raw + POS_SPAN;
        end else if (w_dy_raw > POS_HALF) begin
            w_dy = w_dy_raw - POS_SPAN;
        end else begin
            w_dy = w_dy_raw;
        end
    end

    // Saturating accumulator, symmetric about zero.
    assign w_acc_sum = {r_accum[15], r_accum} + {{5{w_dy[11]}}, w_dy};

    always_comb begin
        if (w_acc_sum > ACC_MAX) begin
            w_acc_sat = ACC_MAX[15:0];
        end else if (w_acc_sum < -ACC_MAX) begin
            w_acc_sat = 16'(-ACC_MAX);
        end else begin
            w_acc_sat = w_acc_sum[15:0];
        end
    end

    assign w_acc_abs = w_acc_sat[15] ? -w_acc_sat : w_acc_sat;
    assign w_eval    = w_acc_abs[14:0] >= r_min_steps;

    // ------------------------------------------------------------------
    // Limiter. The offset subtraction wraps in 16 bits, so the most
    // negative slip values come out large and clamp to the ceiling.
    // ------------------------------------------------------------------
    assign w_lim_raw = r_slip - LIM_OFFSET;

    always_comb begin
        if (w_lim_raw < SLIP_UNIT) begin
            w_lim_s = SLIP_UNIT[9:0];
        end else if (w_lim_raw > SLIP_CEIL) begin
            w_lim_s = SLIP_CEIL[9:0];
        end else begin
            w_lim_s = w_lim_raw[9:0];
        end
    end

    assign w_lim_on = (w_lim_s > SLIP_UNIT[9:0]) && r_limit_en;

    // Flooring shift of the truncated quotient; the low 16 bits are kept.
    assign w_shifted = w_quot >>> r_cal_shift;

    assign w_wrec.dt      = r_time[15:0] - r_win;
    assign w_wrec.stepper = r_delta[15:0];
    assign w_wrec.sensor  = r_accum;

    assign w_out_free = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_word      = r_word;
        n_stepper   = r_stepper;
        n_time      = r_time;
        n_held      = r_held;
        n_perr      = r_perr;
        n_accum     = r_accum;
        n_base      = r_base;
        n_win       = r_win;
        n_slip      = r_slip;
        n_slowdown  = r_slowdown;
        n_limiting  = r_limiting;
        n_delta     = r_delta;
        n_prod      = r_prod;
        n_left      = r_left;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        w_div_start = 1'b0;
        w_ring_ctl  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd     = i_in_data.cmd;
                    n_word    = i_in_data.encoder_word;
                    n_stepper = i_in_data.stepper_position;
                    n_time    = i_in_data.time_ms;
                    n_state   = S_SENSE;
                end
            end
            S_SENSE: begin
                case (r_cmd)
                    CMD_TICK: begin
                        n_held  = w_pos;
                        n_perr  = w_perr;
                        n_accum = w_acc_sat;
                        n_state = w_eval ? S_DELTA : S_EMIT;
                    end
                    CMD_START: begin
                        n_slip     = SLIP_UNIT;
                        n_slowdown = SLOW_NONE;
                        n_limiting = 1'b0;
                        n_base     = r_stepper;
                        n_held     = w_pos;
                        n_perr     = w_perr;
                        n_accum    = '0;
                        n_win      = r_time[15:0];
                        n_state    = S_EMIT;
                    end
                    CMD_DRAIN: begin
                        n_perr = 1'b0;
                        if (w_count != '0) begin
                            n_left  = (32'(w_count) > MAX_RES) ? LEFT_W'(MAX_RES)
                                                               : LEFT_W'(w_count);
                            n_state = S_RD;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                    default: begin
                        n_perr  = 1'b0;
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_DELTA: begin
                n_delta = r_stepper - r_base;
                n_state = S_PROD;
            end
            S_PROD: begin
                n_prod  = PROD_W'(r_delta) * PROD_W'($signed({1'b0, r_cal_value}));
                // An empty window keeps the last slip value.
                n_state = (r_accum == '0) ? S_LIMIT : S_DIVGO;
            end
            S_DIVGO: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_slip  = w_shifted[15:0];
                    n_state = S_LIMIT;
                end
            end
            S_LIMIT: begin
                n_limiting = w_lim_on;
                if (w_lim_on) begin
                    n_slowdown = {w_lim_s, 3'b000};
                end
                w_ring_ctl.push = 1'b1;
                n_base          = r_stepper;
                n_accum         = '0;
                n_win           = r_time[15:0];
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid               = 1'b1;
                    n_out_data.encoder_pos    = r_held;
                    n_out_data.parity_error   = r_perr;
                    n_out_data.slip           = r_slip;
                    n_out_data.slowdown       = r_slowdown;
                    n_out_data.limiting       = r_limiting;
                    n_out_data.record_valid   = 1'b0;
                    n_out_data.record_dt      = '0;
                    n_out_data.record_stepper = '0;
                    n_out_data.record_sensor  = '0;
                    n_out_data.last           = 1'b1;
                    n_state                   = S_IDLE;
                end
            end
            S_RD: begin
                w_ring_ctl.rd = 1'b1;
                n_state       = S_DOUT;
            end
            S_DOUT: begin
                if (w_out_free) begin
                    n_out_valid               = 1'b1;
                    n_out_data.encoder_pos    = r_held;
                    n_out_data.parity_error   = 1'b0;
                    n_out_data.slip           = r_slip;
                    n_out_data.slowdown       = r_slowdown;
                    n_out_data.limiting       = r_limiting;
                    n_out_data.record_valid   = 1'b1;
                    n_out_data.record_dt      = w_rrec.dt;
                    n_out_data.record_stepper = w_rrec.stepper;
                    n_out_data.record_sensor  = w_rrec.sensor;
                    n_out_data.last           = r_left == LEFT_W'(1);
                    w_ring_ctl.pop            = 1'b1;
                    n_left                    = r_left - 1'b1;
                    n_state                   = (r_left == LEFT_W'(1)) ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_perr      <= 1'b0;
            r_accum     <= '0;
            r_base      <= '0;
            r_win       <= '0;
            r_slip      <= SLIP_UNIT;
            r_slowdown  <= SLOW_NONE;
            r_limiting  <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_word      <= n_word;
            r_stepper   <= n_stepper;
            r_time      <= n_time;
            r_held      <= n_held;
            r_perr      <= n_perr;
            r_accum     <= n_accum;
            r_base      <= n_base;
            r_win       <= n_win;
            r_slip      <= n_slip;
            r_slowdown  <= n_slowdown;
            r_limiting  <= n_limiting;
            r_delta     <= n_delta;
            r_prod      <= n_prod;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            r_out_data  <= n_out_data;
        end
    end

    fsmon_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_accum),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    fsmon_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ring_ctl),
        .i_wrec  (w_wrec),
        .o_rrec  (w_rrec),
        .o_count (w_count)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/fsmon_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmon_checker
// Port-level checks on the slip monitor, bound to the top level.
// ----------------------------------------------------------------------------
`include "filament_slip_monitor_core_assert.svh"

module fsmon_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input fsmon_pkg::t_out_item o_out_data
);
    import fsmon_pkg::*;

    logic w_record_ok;

    assign w_record_ok = !o_out_data.parity_error && (o_out_data.slowdown >= SLOW_NONE)
                         && (o_out_data.slowdown <= SLOW_MAX);

    // One beat at a time: the block is busy right after taking a beat.
    `FSMON_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // A stalled result holds.
    `FSMON_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // A status-only result is always the only result of its beat.
    `FSMON_ASSERT_NOW(a_status_last, o_out_valid && !o_out_data.record_valid, o_out_data.last)

    // Drained records never report a parity error, and slowdown stays in range.
    `FSMON_ASSERT_NOW(a_record_clean, o_out_valid && o_out_data.record_valid, w_record_ok)

endmodule

bind filament_slip_monitor_core fsmon_checker u_checker (.*);

[test/filament_slip_monitor_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filament_slip_monitor_core_tb
// Self-checking bench for the filament slip monitor core.
// ----------------------------------------------------------------------------
// A behavioral tracker of the monitor runs beside the core. Every accepted
// input beat is applied to the tracker, which queues the status and record
// beats the core owes. A sink process takes result beats under a changing
// back-pressure pattern and compares each one, field by field, with the
// oldest owed beat. Directed sequences cover the encoder wrap and parity
// cases, the limiter clamp and the empty ring. A saturation sweep and several
// randomized phases with different calibration settings follow.
// ----------------------------------------------------------------------------
module filament_slip_monitor_core_tb;
    import fsmon_pkg::*;

    // The fourth command code has no function in the core.
    localparam logic [1:0] CMD_SPARE     = 2'd3;
    localparam int         RING_N        = RING_DEPTH_DEF;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         TAIL_CYCLES   = 80;
    localparam int         RUN_LIMIT_NS  = 4_000_000;
    localparam int         PHASE_BEATS   = 32;
    localparam int         SWEEP_BEATS   = 67;
    localparam int         SQUEEZE_HOLD  = 400;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} t_stall;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    filament_slip_monitor_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Tracker state: a copy of the configuration and of everything the
    // core remembers between beats.
    // ------------------------------------------------------------------
    logic [14:0]        min_steps;
    logic               lim_en;
    logic [15:0]        cal_val;
    logic [4:0]         cal_sh;

    logic [9:0]         held_pos;
    int                 acc;
    logic [31:0]        base_steps;
    logic [31:0]        win_start;
    logic signed [15:0] slip_now;
    logic [12:0]        slow_now;
    logic               limit_now;
    logic [15:0]        ring_dt [RING_N];
    logic [15:0]        ring_st [RING_N];
    logic [15:0]        ring_se [RING_N];
    int                 ring_head;
    int                 ring_count;

    // Status and record beats owed by the core, oldest first.
    t_out_item          status_due [$];
    int                 mismatches = 0;

    // Stimulus bookkeeping: where the simulated filament, axis and clock are.
    logic [9:0]         trk_pos  = '0;
    logic [31:0]        steps    = '0;
    logic [31:0]        clock_ms = 32'h0000_0100;

    // Handshake shaping, shared between the sender and the result sink.
    t_stall             stall_mode   = STALL_NONE;
    int                 hold_request = 0;
    int                 gap_max      = 3;
    int                 burst_left   = 0;

    // ------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tracker.
    // ------------------------------------------------------------------
    function automatic void reset_tracker();
        min_steps  = 15'd128;
        lim_en     = 1'b1;
        cal_val    = 16'd1;
        cal_sh     = 5'd0;
        held_pos   = '0;
        acc        = 0;
        base_steps = '0;
        win_start  = '0;
        slip_now   = SLIP_UNIT;
        slow_now   = SLOW_NONE;
        limit_now  = 1'b0;
        ring_head  = 0;
        ring_count = 0;
    endfunction

    // Reads one encoder word. A word with odd parity leaves the held position
    // alone, so its movement is zero. A jump of more than half a turn is taken
    // as a wrap through zero; exactly half a turn is kept as it is.
    function automatic int follow_encoder(input logic [15:0] word, output logic perr);
        logic [9:0] pos;
        int         dy;
        perr = ^word;
        pos  = perr ? held_pos : word[15:6];
        dy   = int'(pos) - int'(held_pos);
        if (dy < -512)
            dy = dy + 1024;
        else if (dy > 512)
            dy = dy - 1024;
        held_pos = pos;
        return dy;
    endfunction

    // Closes a measurement window: slip ratio, limiter, and one ring record.
    task automatic close_window(input logic [31:0] steps_now, input logic [31:0] now);
        logic [31:0]        dsteps;
        longint             q;
        logic signed [15:0] biased;
        int                 clamp;
        int                 slot;
        dsteps = steps_now - base_steps;
        // An empty accumulator leaves the previous slip in place.
        if (acc != 0) begin
            q = (longint'($signed(dsteps)) * longint'(cal_val)) / longint'(acc);
            q = q >>> cal_sh;
            slip_now = q[15:0];
        end
        // The offset subtraction wraps in 16 bits, so the most negative slips
        // turn into large positive values and hit the upper clamp.
        biased = slip_now - LIM_OFFSET;
        clamp  = int'(biased);
        if (clamp < int'(SLIP_UNIT))
            clamp = int'(SLIP_UNIT);
        if (clamp > int'(SLIP_CEIL))
            clamp = int'(SLIP_CEIL);
        limit_now = (clamp > int'(SLIP_UNIT)) && lim_en;
        if (limit_now)
            slow_now = 13'(clamp * 8);
        // A full ring gives up its oldest record.
        if (ring_count >= RING_N) begin
            ring_head  = (ring_head + 1) % RING_N;
            ring_count = RING_N - 1;
        end
        slot = (ring_head + ring_count) % RING_N;
        ring_dt[slot] = now[15:0] - win_start[15:0];
        ring_st[slot] = dsteps[15:0];
        ring_se[slot] = acc[15:0];
        ring_count++;
        base_steps = steps_now;
        acc        = 0;
        win_start  = now;
    endtask

    function automatic t_out_item make_status(input logic perr);
        t_out_item r;
        r              = '0;
        r.encoder_pos  = held_pos;
        r.parity_error = perr;
        r.slip         = slip_now;
        r.slowdown     = slow_now;
        r.limiting     = limit_now;
        r.last         = 1'b1;
        return r;
    endfunction

    // Applies one accepted input beat and queues the beats it causes.
    task automatic track_filament(input t_in_item it);
        int        sum;
        int        n;
        int        k;
        logic      perr;
        t_out_item r;
        perr = 1'b0;
        case (it.cmd)
            CMD_TICK: begin
                sum = acc + follow_encoder(it.encoder_word, perr);
                if (sum > 32767)
                    sum = 32767;
                if (sum < -32767)
                    sum = -32767;
                acc = sum;
                if ((sum < 0 ? -sum : sum) >= int'(min_steps))
                    close_window(it.stepper_position, it.time_ms);
                status_due.push_back(make_status(perr));
            end
            CMD_START: begin
                slip_now   = SLIP_UNIT;
                slow_now   = SLOW_NONE;
                limit_now  = 1'b0;
                base_steps = it.stepper_position;
                void'(follow_encoder(it.encoder_word, perr));
                acc        = 0;
                win_start  = it.time_ms;
                status_due.push_back(make_status(perr));
            end
            default: begin
                if (it.cmd == CMD_DRAIN && ring_count > 0) begin
                    n = (ring_count > MAX_RES) ? MAX_RES : ring_count;
                    for (k = 0; k < n; k++) begin
                        r                = make_status(1'b0);
                        r.record_valid   = 1'b1;
                        r.record_dt      = ring_dt[ring_head];
                        r.record_stepper = ring_st[ring_head];
                        r.record_sensor  = ring_se[ring_head];
                        r.last           = (k == n - 1);
                        status_due.push_back(r);
                        ring_head  = (ring_head + 1) % RING_N;
                        ring_count--;
                    end
                end else begin
                    // Empty drain and the spare code both answer with status.
                    status_due.push_back(make_status(1'b0));
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_beat(input t_out_item got);
        t_out_item want;
        if (status_due.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing owed", got));
        end else begin
            want = status_due.pop_front();
            check_field("encoder_pos", got.encoder_pos, want.encoder_pos);
            check_field("parity_error", got.parity_error, want.parity_error);
            check_field("slip", got.slip, want.slip);
            check_field("slowdown", got.slowdown, want.slowdown);
            check_field("limiting", got.limiting, want.limiting);
            check_field("record_valid", got.record_valid, want.record_valid);
            check_field("record_dt", got.record_dt, want.record_dt);
            check_field("record_stepper", got.record_stepper, want.record_stepper);
            check_field("record_sensor", got.record_sensor, want.record_sensor);
            check_field("last", got.last, want.last);
        end
    endtask

    // Result sink. Outputs are read right after the rising edge, before any
    // register of this step has updated, so they hold the values sampled at
    // the edge. A requested hold-off is counted down here, cycle by cycle;
    // otherwise ready follows the current stall mode.
    initial begin : result_sink
        int cyc;
        int hold_left;
        cyc       = 0;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                check_beat(o_out_data);
            cyc++;
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    STALL_NONE:   i_out_ready <= 1'b1;
                    STALL_RANDOM: i_out_ready <= ($urandom_range(0, 2) != 0);
                    default:      i_out_ready <= ((cyc % 7) >= 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------

    // Offers one input beat and holds it until the core takes it. Beats go
    // out in bursts of random length; between bursts valid drops for a
    // random gap, unless gaps are switched off for the phase.
    task automatic send_beat(input t_in_item it);
        if (gap_max > 0 && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        track_filament(it);
    endtask

    // Register write: a setup phase, then an access phase that ends at the
    // edge where pready is seen high, then the port goes idle before returning.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_STEPS: min_steps = value[14:0];
            REG_LIMIT_EN:  lim_en    = value[0];
            REG_CAL_VALUE: cal_val   = value[15:0];
            REG_CAL_SHIFT: cal_sh    = value[4:0];
            default:       cal_sh    = cal_sh;
        endcase
        @(posedge i_clk);
    endtask

    // Stops offering beats and waits until every owed beat has arrived.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Encoder word for a position, with even parity when good is set.
    function automatic logic [15:0] enc_word(input logic [9:0] pos, input bit good);
        logic [15:0] w;
        w[15:6] = pos;
        w[5:0]  = 6'($urandom_range(0, 63));
        w[0]    = (^w[15:1]) ^ !good;
        return w;
    endfunction

    // Moves filament and axis, advances the clock and sends a tick or start.
    task automatic move_and_send(input logic [1:0] cmd, input int enc_step,
                                 input int step_delta, input bit good);
        t_in_item it;
        trk_pos  = trk_pos + enc_step[9:0];
        steps    = steps + step_delta;
        clock_ms = clock_ms + $urandom_range(5, 15);
        it.cmd              = cmd;
        it.encoder_word     = enc_word(trk_pos, good);
        it.stepper_position = steps;
        it.time_ms          = clock_ms;
        send_beat(it);
    endtask

    // A drain or the spare code, with junk in the fields they ignore.
    task automatic send_other(input logic [1:0] cmd);
        t_in_item it;
        it.cmd              = cmd;
        it.encoder_word     = 16'($urandom);
        it.stepper_position = $urandom;
        it.time_ms          = $urandom;
        send_beat(it);
    endtask

    // A tick with fully random content: jumps in position, axis and clock.
    task automatic send_noise();
        t_in_item it;
        it.cmd              = CMD_TICK;
        it.encoder_word     = 16'($urandom);
        it.stepper_position = $urandom;
        it.time_ms          = $urandom;
        if (^it.encoder_word == 1'b0)
            trk_pos = it.encoder_word[15:6];
        steps    = it.stepper_position;
        clock_ms = it.time_ms;
        send_beat(it);
    endtask

    // A plausible tick: the axis moves ratio8/8 steps per encoder count,
    // mostly forward, sometimes backward.
    task automatic random_tick(input int ratio8, input bit good);
        int e;
        e = $urandom_range(4, 60);
        if ($urandom_range(0, 9) == 0)
            e = -e;
        move_and_send(CMD_TICK, e, (e * ratio8) / 8, good);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Drain on an empty ring and the spare command code.
    task automatic test_empty_ring();
        send_other(CMD_DRAIN);
        send_other(CMD_SPARE);
    endtask

    // Parity error, moves of exactly half a turn both ways, and wraps
    // through zero in both directions.
    task automatic test_encoder_wrap();
        move_and_send(CMD_START, 100, 0, 1'b1);
        move_and_send(CMD_TICK, 300, 40, 1'b0);
        move_and_send(CMD_TICK, 212, 400, 1'b1);
        move_and_send(CMD_TICK, -512, -400, 1'b1);
        move_and_send(CMD_TICK, 900, 70, 1'b1);
        move_and_send(CMD_TICK, 44, 30, 1'b1);
        send_other(CMD_DRAIN);
    endtask

    // A slip near the negative limit wraps through the offset and clamps
    // high; a moderate slip limits normally; with the limiter disabled the
    // slow-down factor keeps its last value.
    task automatic test_limiter();
        settle();
        write_reg(REG_LIMIT_EN, 32'd1);
        move_and_send(CMD_START, 0, 0, 1'b1);
        move_and_send(CMD_TICK, 200, -32760 * 200, 1'b1);
        move_and_send(CMD_TICK, 200, 200 * 200, 1'b1);
        settle();
        write_reg(REG_LIMIT_EN, 32'd0);
        move_and_send(CMD_TICK, 200, 300 * 200, 1'b1);
        settle();
        write_reg(REG_LIMIT_EN, 32'd1);
    endtask

    // With a minimum of zero, a tick with no movement still evaluates; the
    // slip stays, the limiter runs, and a record is stored.
    task automatic test_zero_minimum();
        settle();
        write_reg(REG_MIN_STEPS, 32'd0);
        move_and_send(CMD_TICK, 0, 77, 1'b1);
        move_and_send(CMD_TICK, 9, 5, 1'b0);
        settle();
        write_reg(REG_MIN_STEPS, 32'd128);
        send_other(CMD_DRAIN);
    endtask

    // Largest minimum: the accumulator only gets there by saturating, first
    // upward and then downward.
    task automatic test_accum_saturation();
        settle();
        write_reg(REG_MIN_STEPS, 32'd32767);
        move_and_send(CMD_START, 0, 0, 1'b1);
        repeat (SWEEP_BEATS)
            move_and_send(CMD_TICK, $urandom_range(500, 512), $urandom_range(0, 2000), 1'b1);
        move_and_send(CMD_START, 0, 0, 1'b1);
        repeat (SWEEP_BEATS)
            move_and_send(CMD_TICK, 0 - int'($urandom_range(500, 512)),
                          $urandom_range(0, 2000), 1'b1);
        send_other(CMD_DRAIN);
    endtask

    // One randomized phase under a given configuration and handshake style.
    // Most beats are plausible ticks; starts, drains, parity errors, the
    // spare code and noise ticks are mixed in.
    task automatic run_random_phase(input logic [14:0] min_v, input bit en_v,
                                    input logic [15:0] cal_v, input logic [4:0] sh_v,
                                    input t_stall mode, input int gaps,
                                    input bit squeeze, input int drain_pct);
        int ratio8;
        int pick;
        settle();
        write_reg(REG_MIN_STEPS, 32'(min_v));
        write_reg(REG_LIMIT_EN, 32'(en_v));
        write_reg(REG_CAL_VALUE, 32'(cal_v));
        write_reg(REG_CAL_SHIFT, 32'(sh_v));
        stall_mode = mode;
        gap_max    = gaps;
        // The sink holds off for a long stretch while beats keep coming, so
        // the core backs up and stops taking input.
        if (squeeze)
            hold_request = SQUEEZE_HOLD;
        ratio8 = $urandom_range(4, 24);
        move_and_send(CMD_START, 0, 0, 1'b1);
        repeat (PHASE_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < drain_pct) begin
                send_other(CMD_DRAIN);
            end else if (pick < drain_pct + 4) begin
                send_other(CMD_SPARE);
            end else if (pick < drain_pct + 10) begin
                ratio8 = $urandom_range(4, 24);
                move_and_send(CMD_START, $urandom_range(0, 20), 0, 1'b1);
            end else if (pick < drain_pct + 18) begin
                random_tick(ratio8, 1'b0);
            end else if (pick < drain_pct + 22) begin
                send_noise();
            end else begin
                random_tick(ratio8, 1'b1);
            end
        end
        send_other(CMD_DRAIN);
    endtask

    task automatic test_random_phases();
        run_random_phase(15'd128, 1'b1, 16'd128, 5'd0, STALL_NONE, 0, 1'b0, 8);
        // Every tick that moves the encoder evaluates and drains are rare, so the ring overflows.
        run_random_phase(15'd1, 1'b1, 16'hFFFF, 5'd31, STALL_RANDOM, 6, 1'b0, 2);
        run_random_phase(15'd40, 1'b0, 16'd0, 5'd0, STALL_PATTERN, 3, 1'b1, 8);
        run_random_phase(15'($urandom_range(1, 300)), 1'b1, 16'($urandom),
                         5'($urandom_range(0, 8)), STALL_RANDOM, 20, 1'b0, 6);
        run_random_phase(15'd64, 1'b1, 16'd1024, 5'd3, STALL_PATTERN, 2, 1'b0, 10);
    endtask

    // ------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        reset_tracker();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_ring();
        test_encoder_wrap();
        test_limiter();
        test_zero_minimum();
        test_accum_saturation();
        test_random_phases();

        // Let the last beats come out, then watch a while for strays.
        i_in_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
